// ===== design/pdt_pkg.sv =====
// Shared types, opcodes and constants of the packed date/time tick counter.
package pdt_pkg;

	// opcodes
	localparam logic [1:0] OP_TICK      = 2'd0;
	localparam logic [1:0] OP_LOAD_TIME = 2'd1;
	localparam logic [1:0] OP_LOAD_DATE = 2'd2;

	localparam logic [11:0] TICK_PERIOD_MS = 12'd2000;
	localparam logic [10:0] ACC_SAT        = 11'd1999;

	// time word fields
	localparam logic [15:0] TIME_SEC_CLR   = 16'hFFE0;
	localparam logic [15:0] TIME_MIN_INC   = 16'h0020;
	localparam logic [5:0]  TIME_MIN_WRAP  = 6'd60;
	localparam logic [15:0] TIME_MIN_CLR   = 16'hF81F;
	localparam logic [15:0] TIME_HOUR_INC  = 16'h0800;
	localparam logic [4:0]  TIME_SEC_WRAP  = 5'd30;
	localparam logic [4:0]  TIME_HOUR_WRAP = 5'd24;

	// date word fields
	localparam logic [15:0] DATE_DAY_CLR   = 16'hFFE0;
	localparam logic [15:0] DATE_MONTH_INC = 16'h0021;
	localparam logic [3:0]  DATE_MONTH_MAX = 4'd12;
	localparam logic [15:0] DATE_YEAR_KEEP = 16'hFE00;
	localparam logic [15:0] DATE_YEAR_INC  = 16'h0221;
	localparam logic [4:0]  DATE_DAY_LAST  = 5'd31;
	localparam logic [4:0]  DATE_DAY_FEB   = 5'd28;
	localparam logic [4:0]  DATE_DAY_LEAP  = 5'd29;
	localparam logic [3:0]  MONTH_FEB      = 4'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [10:0] tick_ms;
		logic [15:0] load_value;
	} cmd_t;

	typedef struct packed {
		logic [15:0] time_word;
		logic [15:0] date_word;
		logic [31:0] uptime_ms;
	} rsp_t;

	// time advance result
	typedef struct packed {
		logic [15:0] time_word;
		logic        day_wrap;
	} tadv_t;

	// days per month; unused month codes have none
	function automatic logic [4:0] month_len(input logic [3:0] mon);
		logic [4:0] len;
		unique case (mon)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd2:                                     len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
			default:                                  len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ===== design/pdt_date_adv.sv =====
// One-day advance of the packed date word.
module pdt_date_adv (
	input  logic [15:0] date_cur,
	output logic [15:0] date_nxt
);
	import pdt_pkg::*;

	logic [15:0] inc;
	logic [15:0] d;
	logic [15:0] m;
	logic        bump;
	logic        leap_feb;

	always_comb begin
		inc      = date_cur + 16'd1;
		leap_feb = (inc[8:5] == MONTH_FEB) && (inc[10:9] == 2'd0);
		if (date_cur[4:0] == DATE_DAY_LAST) begin
			d    = date_cur;
			bump = 1'b1;
		end else begin
			d = inc;
			if (inc[4:0] > DATE_DAY_FEB) begin
				bump = leap_feb ? (inc[4:0] > DATE_DAY_LEAP)
				                : (inc[4:0] > month_len(inc[8:5]));
			end else begin
				bump = 1'b0;
			end
		end
		m = (d & DATE_DAY_CLR) + DATE_MONTH_INC;
		if (m[8:5] > DATE_MONTH_MAX) begin
			m = (m & DATE_YEAR_KEEP) + DATE_YEAR_INC;
		end
		date_nxt = bump ? m : d;
	end

endmodule

// ===== design/pdt_time_adv.sv =====
// One 2-second advance of the packed time word, with day wrap flag.
module pdt_time_adv (
	input  logic [15:0]   time_cur,
	output pdt_pkg::tadv_t adv
);
	import pdt_pkg::*;

	logic [15:0] t;

	always_comb begin
		t            = time_cur + 16'd1;
		adv.day_wrap = 1'b0;
		if (t[4:0] == TIME_SEC_WRAP) begin
			t = (t & TIME_SEC_CLR) + TIME_MIN_INC;
			if (t[10:5] == TIME_MIN_WRAP) begin
				t = (t & TIME_MIN_CLR) + TIME_HOUR_INC;
				if (t[15:11] == TIME_HOUR_WRAP) begin
					t            = 16'd0;
					adv.day_wrap = 1'b1;
				end
			end
		end
		adv.time_word = t;
	end

endmodule

// ===== design/packed_date_time_tick_counter.sv =====
// Top level of the packed date/time tick counter.
// Each command item (tick, load time word, load date word) yields exactly one
// result item with the time word, date word and uptime as they stand after
// that command. Throughput is one item per clock: the command sits in an
// input register, the tick/time/date update is a short add-and-compare chain
// that writes the state registers and the result register in the same cycle,
// so the next command sees the updated state right away. Result valid is set
// in the result register, behind the input register. The result register and the
// input register together let one new item in while a finished result waits;
// if the result side stalls longer, cmd_ready drops. A tick moves the time
// word by at most one 2-second step; a surplus beyond that saturates the
// millisecond accumulator at 1999. Hour 24 clears the time word and advances
// the date by one day, with a leap February when the year field is a
// multiple of four. Opcode 3 changes nothing and just reports the state.
module packed_date_time_tick_counter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  pdt_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pdt_pkg::rsp_t rsp
);
	import pdt_pkg::*;

	// input stage
	logic        cmd_valid_s1;
	cmd_t        cmd_s1;
	// result stage
	logic        rsp_valid_s2;
	rsp_t        rsp_s2;
	// clock state
	logic [10:0] ms_acc_q;
	logic [15:0] time_q;
	logic [15:0] date_q;
	logic [31:0] uptime_q;

	logic        advance;
	logic        s1_fire;

	logic [11:0] acc_sum;
	logic [11:0] acc_sub;
	logic        step;
	logic [10:0] acc_nxt;
	tadv_t       tadv;
	logic [15:0] date_adv;

	logic [10:0] ms_acc_d;
	logic [15:0] time_d;
	logic [15:0] date_d;
	logic [31:0] uptime_d;

	// result register frees up when empty or being taken
	assign advance   = !rsp_valid_s2 || rsp_ready;
	assign s1_fire   = cmd_valid_s1 && advance;
	assign cmd_ready = !cmd_valid_s1 || advance;
	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	pdt_time_adv u_time (
		.time_cur (time_q),
		.adv      (tadv)
	);

	pdt_date_adv u_date (
		.date_cur (date_q),
		.date_nxt (date_adv)
	);

	// millisecond accumulator: one 2 s step at most, saturating leftover
	always_comb begin
		acc_sum = {1'b0, ms_acc_q} + {1'b0, cmd_s1.tick_ms};
		acc_sub = acc_sum - TICK_PERIOD_MS;
		step    = acc_sum >= TICK_PERIOD_MS;
		if (!step) begin
			acc_nxt = acc_sum[10:0];
		end else if (acc_sub >= TICK_PERIOD_MS) begin
			acc_nxt = ACC_SAT;
		end else begin
			acc_nxt = acc_sub[10:0];
		end
	end

	always_comb begin
		ms_acc_d = ms_acc_q;
		time_d   = time_q;
		date_d   = date_q;
		uptime_d = uptime_q;
		unique case (cmd_s1.opcode)
			OP_TICK: begin
				ms_acc_d = acc_nxt;
				uptime_d = uptime_q + {21'd0, cmd_s1.tick_ms};
				if (step) begin
					time_d = tadv.time_word;
					if (tadv.day_wrap) begin
						date_d = date_adv;
					end
				end
			end
			OP_LOAD_TIME: time_d = cmd_s1.load_value;
			OP_LOAD_DATE: date_d = cmd_s1.load_value;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			cmd_valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= cmd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_s2.time_word <= time_d;
			rsp_s2.date_word <= date_d;
			rsp_s2.uptime_ms <= uptime_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_acc_q <= '0;
			time_q   <= '0;
			date_q   <= '0;
			uptime_q <= '0;
		end else if (s1_fire) begin
			ms_acc_q <= ms_acc_d;
			time_q   <= time_d;
			date_q   <= date_d;
			uptime_q <= uptime_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, ms_acc_q} < TICK_PERIOD_MS)
		else $error("ms accumulator out of range");

	a_uptime_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_fire && cmd_s1.opcode == OP_TICK) |=> $stable(uptime_q))
		else $error("uptime moved without a tick");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> rsp_valid_s2)
		else $error("processed item lost before result stage");

	a_rsp_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> (rsp_s2.time_word == time_q && rsp_s2.date_word == date_q
			&& rsp_s2.uptime_ms == uptime_q))
		else $error("result does not match updated state");
`endif

endmodule

// ===== dv/tb_packed_date_time_tick_counter.sv =====
// Testbench for the packed date/time tick counter: directed rows, random sequences, scoreboard.
module tb_packed_date_time_tick_counter;
	import pdt_pkg::*;

	// the package names three opcodes; the fourth code is a no-op that reports state
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int RANDOM_ITEMS = 450;
	localparam int LIMIT_CYCLES = 300000;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_ready;
	cmd_t  cmd       = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	packed_date_time_tick_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// one directed row: the item, and a typed-in result where it is obvious
	typedef struct packed {
		cmd_t c;
		logic golden;
		rsp_t r;
	} dir_row_t;

	dir_row_t directed_rows[$];
	rsp_t     pending_rsp[$];   // results owed by the block, oldest first

	int errors         = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int sent_random    = 0;

	// shadow copy of the block state
	logic [10:0] shadow_ms     = '0;
	logic [15:0] shadow_time   = '0;
	logic [15:0] shadow_date   = '0;
	logic [31:0] shadow_uptime = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: generous even for the slowest idling phase
	initial begin
		#(12 * LIMIT_CYCLES);
		$display("DONE: errors detected");
		$finish;
	end

	// -------------------------------------------------------------------
	// Calendar arithmetic. Plain 16-bit adds and compares, so odd
	// loaded fields carry into their neighbors exactly as the block does.
	// -------------------------------------------------------------------
	function automatic logic [15:0] next_day(input logic [15:0] d);
		logic       bump;
		logic [4:0] mdays;
		bump = 1'b0;
		if (d[4:0] == 5'd31) begin
			// day 31 always rolls the month, whatever the month is
			bump = 1'b1;
		end else begin
			d = d + 16'd1;
			if (d[4:0] > 5'd28) begin
				case (d[8:5])
					4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: mdays = 5'd31;
					4'd4, 4'd6, 4'd9, 4'd11:                  mdays = 5'd30;
					4'd2:                                     mdays = 5'd28;
					default:                                  mdays = 5'd0;
				endcase
				// leap February when the low two year bits are clear
				if (d[8:5] == 4'd2 && d[10:9] == 2'b00)
					mdays = 5'd29;
				bump = d[4:0] > mdays;
			end
		end
		if (bump) begin
			d = (d & 16'hFFE0) + 16'h0021;
			if (d[8:5] > 4'd12)
				d = (d & 16'hFE00) + 16'h0221;
		end
		return d;
	endfunction

	// one 2-second step; midnight clears the time word and moves the date
	function automatic void step_two_seconds();
		logic [15:0] t;
		t = shadow_time + 16'd1;
		if (t[4:0] == 5'd30) begin
			t = (t & 16'hFFE0) + 16'h0020;
			if (t[10:5] == 6'd60) begin
				t = (t & 16'hF81F) + 16'h0800;
				if (t[15:11] == 5'd24) begin
					t = '0;
					shadow_date = next_day(shadow_date);
				end
			end
		end
		shadow_time = t;
	endfunction

	// apply one item to the shadow state and return the result it owes
	function automatic rsp_t clock_calendar_step(input cmd_t c);
		logic [11:0] acc;
		rsp_t        r;
		case (c.opcode)
			OP_TICK: begin
				acc = {1'b0, shadow_ms} + {1'b0, c.tick_ms};
				shadow_uptime = shadow_uptime + 32'(c.tick_ms);
				if (acc >= 12'd2000) begin
					acc = acc - 12'd2000;
					// only one step per tick; the surplus saturates
					if (acc >= 12'd2000)
						acc = 12'd1999;
					step_two_seconds();
				end
				shadow_ms = acc[10:0];
			end
			OP_LOAD_TIME: shadow_time = c.load_value;
			OP_LOAD_DATE: shadow_date = c.load_value;
			default: ;
		endcase
		r.time_word = shadow_time;
		r.date_word = shadow_date;
		r.uptime_ms = shadow_uptime;
		return r;
	endfunction

	// -------------------------------------------------------------------
	// Driving: fields change at the falling edge, acceptance is seen at
	// the rising edge. Valid stays up with a steady payload until taken.
	// -------------------------------------------------------------------
	task automatic send_item(input cmd_t c, input logic golden, input rsp_t gold);
		rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (!cmd_ready);
		want = clock_calendar_step(c);
		pending_rsp.push_back(golden ? gold : want);
		@(negedge clk);
	endtask

	task automatic add_row(input logic [1:0] op, input logic [10:0] tick,
			input logic [15:0] load, input logic golden,
			input logic [15:0] t, input logic [15:0] d, input logic [31:0] up);
		dir_row_t row;
		row.c.opcode     = op;
		row.c.tick_ms    = tick;
		row.c.load_value = load;
		row.golden       = golden;
		row.r.time_word  = t;
		row.r.date_word  = d;
		row.r.uptime_ms  = up;
		directed_rows.push_back(row);
	endtask

	// random item; the idling phase follows from how far the run has got
	task automatic send_random(input logic [1:0] op, input logic [10:0] tick,
			input logic [15:0] load);
		cmd_t c;
		case (sent_random * 4 / RANDOM_ITEMS)
			0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1:       begin send_idle_pct = 74; recv_stall_pct = 0;  end
			2:       begin send_idle_pct = 0;  recv_stall_pct = 74; end
			default: begin send_idle_pct = 29; recv_stall_pct = 29; end
		endcase
		c.opcode     = op;
		c.tick_ms    = tick;
		c.load_value = load;
		send_item(c, 1'b0, '0);
		if (op != OP_NONE)
			sent_random++;
	endtask

	// mostly large ticks so the time word keeps moving
	function automatic logic [10:0] pick_tick();
		if ($urandom_range(99) < 60)
			return 11'($urandom_range(2047, 1500));
		return 11'($urandom_range(2047));
	endfunction

	// time word: hour 23 and minute 59 each most of the time, seconds 26 to 31
	function automatic logic [15:0] pick_time();
		logic [4:0] hh;
		logic [5:0] mm;
		logic [4:0] ss;
		hh = ($urandom_range(99) < 70) ? 5'd23 : 5'($urandom_range(31));
		mm = ($urandom_range(99) < 70) ? 6'd59 : 6'($urandom_range(63));
		ss = 5'($urandom_range(31, 26));
		return {hh, mm, ss};
	endfunction

	// date word near a month end, with odd months and days now and then
	function automatic logic [15:0] pick_date();
		logic [6:0] yy;
		logic [3:0] mo;
		logic [4:0] dd;
		yy = 7'($urandom_range(127));
		mo = ($urandom_range(99) < 70) ? 4'($urandom_range(12, 1)) : 4'($urandom_range(15));
		dd = ($urandom_range(99) < 70) ? 5'($urandom_range(31, 26)) : 5'($urandom_range(31));
		return {yy, mo, dd};
	endfunction

	// receiver: random backpressure per the current phase
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

	// scoreboard: every taken result against the oldest expectation
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.time_word !== want.time_word) begin
					errors++;
					$display("%0t: time_word expected %h actual %h",
						$time, want.time_word, rsp.time_word);
				end
				if (rsp.date_word !== want.date_word) begin
					errors++;
					$display("%0t: date_word expected %h actual %h",
						$time, want.date_word, rsp.date_word);
				end
				if (rsp.uptime_ms !== want.uptime_ms) begin
					errors++;
					$display("%0t: uptime_ms expected %0d actual %0d",
						$time, want.uptime_ms, rsp.uptime_ms);
				end
			end
		end
	end

	initial begin : stimulus
		int kind;
		int n;
		// directed rows; typed results only where obvious from reset state
		add_row(OP_NONE,      11'd0,    16'h0000, 1'b1, 16'h0000, 16'h0000, 32'd0);
		add_row(OP_TICK,      11'd0,    16'h0000, 1'b1, 16'h0000, 16'h0000, 32'd0);
		add_row(OP_TICK,      11'd1999, 16'h0000, 1'b1, 16'h0000, 16'h0000, 32'd1999);
		// largest tick: one step only, accumulator saturates at 1999
		add_row(OP_TICK,      11'd2047, 16'h0000, 1'b1, 16'h0001, 16'h0000, 32'd4046);
		add_row(OP_LOAD_TIME, 11'd0,    16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 32'd4046);
		add_row(OP_LOAD_DATE, 11'd0,    16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 32'd4046);
		// time word wraps in 16 bits
		add_row(OP_TICK,      11'd1,    16'h0000, 1'b0, '0, '0, '0);
		// leap February in year 0: Feb 28 -> Feb 29 -> Mar 1
		add_row(OP_LOAD_TIME, 11'd0,    16'hBF7D, 1'b0, '0, '0, '0);
		add_row(OP_LOAD_DATE, 11'd0,    16'h005C, 1'b0, '0, '0, '0);
		add_row(OP_TICK,      11'd2000, 16'h0000, 1'b0, '0, '0, '0);
		add_row(OP_LOAD_TIME, 11'd0,    16'hBF7D, 1'b0, '0, '0, '0);
		add_row(OP_TICK,      11'd2000, 16'h0000, 1'b0, '0, '0, '0);
		// common-year February 28 rolls straight to March
		add_row(OP_LOAD_DATE, 11'd0,    16'h025C, 1'b0, '0, '0, '0);
		add_row(OP_LOAD_TIME, 11'd0,    16'hBF7D, 1'b0, '0, '0, '0);
		add_row(OP_TICK,      11'd2000, 16'h0000, 1'b0, '0, '0, '0);
		// December 31 of the last year wraps the year field
		add_row(OP_LOAD_DATE, 11'd0,    16'hFF9F, 1'b0, '0, '0, '0);
		add_row(OP_LOAD_TIME, 11'd0,    16'hBF7D, 1'b0, '0, '0, '0);
		add_row(OP_TICK,      11'd2000, 16'h0000, 1'b0, '0, '0, '0);
		// 30-day month end
		add_row(OP_LOAD_DATE, 11'd0,    16'h009E, 1'b0, '0, '0, '0);
		add_row(OP_LOAD_TIME, 11'd0,    16'hBF7D, 1'b0, '0, '0, '0);
		add_row(OP_TICK,      11'd2000, 16'h0000, 1'b0, '0, '0, '0);
		// month 0 has no days, so day 29 bumps it
		add_row(OP_LOAD_DATE, 11'd0,    16'h001C, 1'b0, '0, '0, '0);
		add_row(OP_LOAD_TIME, 11'd0,    16'hBF7D, 1'b0, '0, '0, '0);
		add_row(OP_TICK,      11'd2000, 16'h0000, 1'b0, '0, '0, '0);
		// unused opcode with every field bit set changes nothing
		add_row(OP_NONE,      11'h7FF,  16'hFFFF, 1'b0, '0, '0, '0);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].c, directed_rows[i].golden, directed_rows[i].r);

		// random part: mostly set-up-then-tick sequences that cross midnight
		while (sent_random < RANDOM_ITEMS) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				send_random(OP_LOAD_TIME, 11'($urandom_range(2047)), pick_time());
				send_random(OP_LOAD_DATE, 11'($urandom_range(2047)), pick_date());
				n = $urandom_range(6, 1);
				repeat (n)
					send_random(OP_TICK, pick_tick(), 16'($urandom_range(65535)));
			end else if (kind < 85) begin
				n = $urandom_range(10, 1);
				repeat (n)
					send_random(OP_TICK, 11'($urandom_range(2047)),
						16'($urandom_range(65535)));
			end else begin
				// noise: any opcode, any field content
				send_random(2'($urandom_range(3)), 11'($urandom_range(2047)),
					16'($urandom_range(65535)));
			end
		end
		cmd_valid <= 1'b0;

		// drain, then keep watching the pipeline for strays
		recv_stall_pct = 0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
